FILE: hw/rtl/sfcs_pkg.sv
// ============================================================================
// sfcs_pkg
// Types, codes and the result expansion table for the flash command sequencer.
// ============================================================================
package sfcs_pkg;

    localparam int PAGE_BYTES_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    // request ops
    localparam logic [2:0] OP_READ_ID    = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_PROGRAM    = 3'd2;
    localparam logic [2:0] OP_ERASE_SEC  = 3'd3;
    localparam logic [2:0] OP_ERASE_CHIP = 3'd4;
    localparam logic [2:0] OP_HOST_BYTE  = 3'd5;
    localparam logic [2:0] OP_RESPONSE   = 3'd6;

    // result actions
    localparam logic [2:0] ACT_SEND    = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_READ    = 3'd2;
    localparam logic [2:0] ACT_ID      = 3'd3;
    localparam logic [2:0] ACT_DONE    = 3'd4;
    localparam logic [2:0] ACT_ERROR   = 3'd5;

    // flash opcodes
    localparam logic [7:0] FL_RDID  = 8'h9F;
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_RDSR  = 8'h05;
    localparam logic [7:0] FL_SE    = 8'h20;
    localparam logic [7:0] FL_CE    = 8'hC7;
    localparam logic [7:0] FL_READ  = 8'h03;
    localparam logic [7:0] FL_PP    = 8'h02;
    localparam logic [7:0] FL_DUMMY = 8'hFF;

    localparam logic [2:0] SKIP_MAX = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID,
        PH_READ,
        PH_PDATA,
        PH_FLUSH,
        PH_POLL
    } phase_t;

    typedef enum logic [3:0] {
        CMD_ID,
        CMD_READ,
        CMD_ERROR,
        CMD_CHUNK,
        CMD_NEXT_CHUNK,
        CMD_ERASE_SEC,
        CMD_ERASE_CHIP,
        CMD_HOST,
        CMD_POLL_START,
        CMD_DONE,
        CMD_FINISH_ID,
        CMD_READ_BYTE,
        CMD_POLL_MORE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        flag;
        logic [23:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] address;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] value;
        logic        last;
    } out_t;

    // One result of a queued command, picked by step.
    function automatic out_t expand(input cmd_t c, input logic [2:0] step);
        out_t       r;
        logic [7:0] v8;
        logic [2:0] ps;
        r.action = ACT_SEND;
        r.value  = '0;
        r.last   = 1'b0;
        v8       = '0;
        ps       = (c.kind == CMD_NEXT_CHUNK) ? step - 3'd1 : step;
        unique case (c.kind)
            CMD_ID:
            begin
                v8     = (step == 3'd0) ? FL_RDID : FL_DUMMY;
                r.last = (step == 3'd3);
            end
            CMD_READ:
            begin
                unique case (step)
                    3'd0:    v8 = FL_READ;
                    3'd1:    v8 = c.value[23:16];
                    3'd2:    v8 = c.value[15:8];
                    3'd3:    v8 = c.value[7:0];
                    default: v8 = FL_DUMMY;
                endcase
                r.last = (step == (c.flag ? 3'd4 : 3'd3));
            end
            CMD_ERROR:
            begin
                r.action = ACT_ERROR;
                r.last   = 1'b1;
            end
            CMD_CHUNK, CMD_NEXT_CHUNK, CMD_ERASE_SEC:
            begin
                unique case (ps)
                    3'd0:    v8 = FL_WREN;
                    3'd1:    r.action = ACT_RELEASE;
                    3'd2:    v8 = (c.kind == CMD_ERASE_SEC) ? FL_SE : FL_PP;
                    3'd3:    v8 = c.value[23:16];
                    3'd4:    v8 = c.value[15:8];
                    3'd5:    v8 = c.value[7:0];
                    default: r.action = ACT_RELEASE;
                endcase
                if (c.kind == CMD_NEXT_CHUNK && step == 3'd0)
                begin
                    r.action = ACT_RELEASE;
                    v8       = '0;
                end
                r.last = (step == ((c.kind == CMD_CHUNK) ? 3'd5 : 3'd6));
            end
            CMD_ERASE_CHIP:
            begin
                unique case (step)
                    3'd0:    v8 = FL_WREN;
                    3'd2:    v8 = FL_CE;
                    default: r.action = ACT_RELEASE;
                endcase
                r.last = (step == 3'd3);
            end
            CMD_HOST:
            begin
                if (step == 3'd0)
                    v8 = c.value[7:0];
                else
                    r.action = ACT_RELEASE;
                r.last = (step == {2'b00, c.flag});
            end
            CMD_POLL_START:
            begin
                v8     = (step == 3'd0) ? FL_RDSR : FL_DUMMY;
                r.last = (step == 3'd1);
            end
            CMD_DONE:
            begin
                r.action = (step == 3'd0) ? ACT_RELEASE : ACT_DONE;
                r.last   = (step == 3'd1);
            end
            CMD_FINISH_ID:
            begin
                r.action = (step == 3'd0) ? ACT_RELEASE : ACT_ID;
                r.last   = (step == 3'd1);
            end
            CMD_READ_BYTE:
            begin
                if (step == 3'd0)
                begin
                    r.action = ACT_READ;
                    v8       = c.value[7:0];
                end
                else if (c.flag)
                    v8 = FL_DUMMY;
                else
                    r.action = (step == 3'd1) ? ACT_RELEASE : ACT_DONE;
                r.last = (step == (c.flag ? 3'd1 : 3'd2));
            end
            CMD_POLL_MORE:
            begin
                v8     = FL_DUMMY;
                r.last = 1'b1;
            end
            default:
            begin
                r.action = ACT_ERROR;
                r.last   = 1'b1;
            end
        endcase
        if (c.kind == CMD_FINISH_ID && step != 3'd0)
            r.value = c.value;
        else
            r.value = {16'h0000, v8};
        return r;
    endfunction

endpackage

FILE: hw/rtl/spi_nor_flash_command_sequencer_core.sv
// ============================================================================
// spi_nor_flash_command_sequencer_core
// Turns flash requests and received bytes into byte-level SPI actions.
// ============================================================================
// Input channel (in_valid/in_stall/in_data) carries requests: read id, read,
// program, erase sector, erase chip, host data bytes and bytes received from
// the flash. Each request is taken when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall/out_data) carries actions: send a byte,
// release select, read byte, id, done or error; last marks the final action
// caused by one request.
// The front part decodes a request and queues at most one command; the
// back part emits that command's actions at one per cycle while out_stall is
// low, from an output register. The command is written into the queue, then
// each action is loaded into the output register; a queued command has 1 to 7
// actions. Requests are taken every cycle while the command queue has room;
// in_stall rises when the queue is full, which happens when requests with
// several actions arrive faster than the output drains or while out_stall
// holds the output. A stalled action stays on out_data unchanged.
// Reset puts the sequencer idle with no owed responses and empties the queue.
// PAGE_BYTES must be a power of two.
// ============================================================================
module spi_nor_flash_command_sequencer_core
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t q_cmd, q_head;

    sfcs_front #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    sfcs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    sfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/sfcs_front.sv
// ============================================================================
// sfcs_front
// Accepts requests, tracks the transaction phase and queues result commands.
// ============================================================================
module sfcs_front
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic q_full,
    output logic q_push,
    output cmd_t q_cmd
);

    // the user must keep the page size a power of two; the block does not enforce it
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int CW = $clog2(PAGE_BYTES + 1);

    phase_t      phase_reg, phase_next;
    logic [23:0] addr_reg, addr_next;
    logic [15:0] left_reg, left_next;
    logic [CW-1:0] chunk_reg, chunk_next;
    logic [2:0]  skip_reg, skip_next;
    logic [23:0] id_reg, id_next;

    logic        acc, is_req, is_host, is_resp, skip_end, data_resp;
    logic [15:0] left_dec;
    logic [23:0] id_shift;

    function automatic logic [CW-1:0] chunk_of(input logic [23:0] a, input logic [15:0] bl);
        logic [15:0] room;
        room = 16'(PAGE_BYTES) - 16'(a[PW-1:0]);
        return (room < bl) ? CW'(room) : CW'(bl);
    endfunction

    assign in_stall  = q_full;
    assign acc       = in_valid && !q_full;
    assign is_req    = acc && (in_data.op <= OP_ERASE_CHIP) && (phase_reg == PH_IDLE);
    assign is_host   = acc && (in_data.op == OP_HOST_BYTE) && (phase_reg == PH_PDATA)
                       && (skip_reg < SKIP_MAX) && (chunk_reg != '0);
    assign is_resp   = acc && (in_data.op == OP_RESPONSE) && (phase_reg != PH_IDLE);
    assign skip_end  = is_resp && (skip_reg == 3'd1);
    assign data_resp = is_resp && (skip_reg == 3'd0);
    assign left_dec  = (left_reg != '0) ? left_reg - 16'd1 : left_reg;
    assign id_shift  = {id_reg[15:0], in_data.data_byte};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_req)
        begin
            unique case (in_data.op)
                OP_READ_ID: phase_next = PH_ID;
                OP_READ:    phase_next = PH_READ;
                OP_PROGRAM: phase_next = (in_data.byte_count == '0) ? PH_IDLE : PH_PDATA;
                default:    phase_next = PH_FLUSH;
            endcase
        end
        else if (is_host)
        begin
            if (chunk_reg == CW'(1))
                phase_next = PH_FLUSH;
        end
        else if (skip_end)
        begin
            if (phase_reg == PH_FLUSH)
                phase_next = PH_POLL;
            else if (phase_reg == PH_READ && left_reg == '0)
                phase_next = PH_IDLE;
        end
        else if (data_resp)
        begin
            priority case (phase_reg)
                PH_ID:   if (left_dec == '0) phase_next = PH_IDLE;
                PH_READ: if (left_dec == '0) phase_next = PH_IDLE;
                PH_POLL:
                    if (!in_data.data_byte[0])
                        phase_next = (left_reg != '0) ? PH_PDATA : PH_IDLE;
                default: phase_next = phase_reg;
            endcase
        end
    end

    // datapath and queued command
    always_comb
    begin
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        skip_next  = skip_reg;
        id_next    = id_reg;
        q_push     = 1'b0;
        q_cmd.kind  = CMD_ERROR;
        q_cmd.flag  = 1'b0;
        q_cmd.value = in_data.address;
        if (is_req)
        begin
            q_push = 1'b1;
            unique case (in_data.op)
                OP_READ_ID:
                begin
                    q_cmd.kind = CMD_ID;
                    id_next    = '0;
                    left_next  = 16'd3;
                    skip_next  = 3'd1;
                end
                OP_READ:
                begin
                    q_cmd.kind = CMD_READ;
                    q_cmd.flag = (in_data.byte_count != '0);
                    left_next  = in_data.byte_count;
                    skip_next  = 3'd4;
                end
                OP_PROGRAM:
                begin
                    if (in_data.byte_count != '0)
                    begin
                        q_cmd.kind = CMD_CHUNK;
                        addr_next  = in_data.address;
                        left_next  = in_data.byte_count;
                        chunk_next = chunk_of(in_data.address, in_data.byte_count);
                        skip_next  = 3'd5;
                    end
                end
                OP_ERASE_SEC:
                begin
                    q_cmd.kind = CMD_ERASE_SEC;
                    left_next  = '0;
                    skip_next  = 3'd5;
                end
                default:
                begin
                    q_cmd.kind = CMD_ERASE_CHIP;
                    left_next  = '0;
                    skip_next  = 3'd2;
                end
            endcase
        end
        else if (is_host)
        begin
            q_push      = 1'b1;
            q_cmd.kind  = CMD_HOST;
            q_cmd.flag  = (chunk_reg == CW'(1));
            q_cmd.value = {16'h0000, in_data.data_byte};
            skip_next   = skip_reg + 3'd1;
            addr_next   = addr_reg + 24'd1;
            left_next   = left_reg - 16'd1;
            chunk_next  = chunk_reg - CW'(1);
        end
        else if (is_resp && skip_reg != 3'd0)
        begin
            skip_next = skip_reg - 3'd1;
            if (skip_reg == 3'd1)
            begin
                if (phase_reg == PH_FLUSH)
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_POLL_START;
                    skip_next  = 3'd1;
                end
                else if (phase_reg == PH_READ && left_reg == '0)
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_DONE;
                end
            end
        end
        else if (data_resp)
        begin
            priority case (phase_reg)
                PH_ID:
                begin
                    id_next   = id_shift;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        q_push      = 1'b1;
                        q_cmd.kind  = CMD_FINISH_ID;
                        q_cmd.value = id_shift;
                    end
                end
                PH_READ:
                begin
                    left_next   = left_dec;
                    q_push      = 1'b1;
                    q_cmd.kind  = CMD_READ_BYTE;
                    q_cmd.flag  = (left_dec != '0);
                    q_cmd.value = {16'h0000, in_data.data_byte};
                end
                PH_POLL:
                begin
                    q_push = 1'b1;
                    if (in_data.data_byte[0])
                        q_cmd.kind = CMD_POLL_MORE;
                    else if (left_reg != '0)
                    begin
                        q_cmd.kind  = CMD_NEXT_CHUNK;
                        q_cmd.value = addr_reg;
                        chunk_next  = chunk_of(addr_reg, left_reg);
                        skip_next   = 3'd5;
                    end
                    else
                        q_cmd.kind = CMD_DONE;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            skip_reg  <= '0;
            id_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            skip_reg  <= skip_next;
            id_reg    <= id_next;
        end
    end

    a_idle_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (skip_reg == 3'd0))
        else $error("responses owed while idle");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_flush_chunk_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (is_host && chunk_reg == CW'(1)) |=> (phase_reg == PH_FLUSH && chunk_reg == '0))
        else $error("chunk end did not move to flush");

endmodule

FILE: hw/rtl/sfcs_queue.sv
// ============================================================================
// sfcs_queue
// Short command queue between the front and back parts.
// ============================================================================
module sfcs_queue
    import sfcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cmd_t            mem [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CNTW-1:0] count_reg;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + CNTW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNTW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push while full");

endmodule

FILE: hw/rtl/sfcs_back.sv
// ============================================================================
// sfcs_back
// Expands queued commands into byte-level results, one per cycle while out_stall is low.
// ============================================================================
module sfcs_back
    import sfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    out_t       data_reg;
    out_t       res;
    logic       load;

    assign res       = expand(q_head, step_reg);
    assign load      = !valid_reg || !out_stall;
    assign q_pop     = load && !q_empty && res.last;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
                step_next = res.last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd6)
        else $error("expansion step out of range");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (step_reg == 3'd0))
        else $error("step left over with empty queue");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled action changed");

endmodule
